// ===== design/button_debounce_autorepeat_top_macros.svh =====
// Assertion macros shared by the button debounce and autorepeat design.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property on every rising clock edge outside reset.
`define BDA_ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition never holds on a rising clock edge outside reset.
`define BDA_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BDA_ASSERT_PROP(label, clk, rst, prop, msg)
`define BDA_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ===== design/bda_pkg.sv =====
// Package with the types and constants of the button debounce and autorepeat block.
`timescale 1ns / 1ps

package bda_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int LEVELS_W    = 8;
  localparam int SCAN_LIMIT  = (NUM_BUTTONS < LEVELS_W) ? NUM_BUTTONS : LEVELS_W;
  localparam logic [LEVELS_W-1:0] SCAN_MASK = LEVELS_W'((1 << SCAN_LIMIT) - 1);

  localparam int INDEX_W = 3;
  localparam int TICKS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 16'd64;
  localparam logic [TICKS_W-1:0] DELAY_RESET    = 16'd750;
  localparam logic [TICKS_W-1:0] INTERVAL_RESET = 16'd256;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK     = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_REPEAT   = 2'd2
  } phase_t;

  // A wait length of zero behaves as one tick.
  function automatic logic [TICKS_W-1:0] load_wait(input logic [TICKS_W-1:0] ticks);
    load_wait = (ticks == '0) ? TICKS_W'(1) : ticks;
  endfunction

endpackage

// ===== design/button_debounce_autorepeat_top.sv =====
// Top level of the button debounce and autorepeat block.
`timescale 1ns / 1ps
`include "button_debounce_autorepeat_top_macros.svh"

// Each input transfer is one time tick carrying the pressed levels of up to
// eight buttons, and each one yields exactly one result transfer. When the
// block is enabled and idle, the lowest-index pressed button is reported with
// fire set and a debounce wait starts. At the end of a wait the block goes
// idle if the button was released; a button marked in repeat_mask then waits
// repeat_delay_ticks and fires every repeat_interval_ticks while held, any
// other button just restarts the debounce wait. A wait of D ticks ends on the
// D-th tick after it was loaded, and a zero wait acts as one tick. Writing 0
// to enable forces the block idle at once. The block takes one tick per clock
// cycle and its result appears in the output register in the cycle after; the
// state update and the result both come out of one pass of shallow logic (a
// priority encoder and a 16-bit down-counter), and the single output register
// is the only thing that holds input off, namely while a result waits to be
// taken. Configuration writes are meant for times when no tick is in flight.
module button_debounce_autorepeat_top (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [bda_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Tick stream in.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bda_pkg::LEVELS_W-1:0]       s_tdata,   // [7:0] pressed_levels
  // Result stream out.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bda_pkg::OUT_DATA_W-1:0]     m_tdata    // [0] fire, [3:1] button_index,
                                                        // [7:4] zero
);
  import bda_pkg::*;

  // Configuration registers.
  logic                enable;
  logic [TICKS_W-1:0]  debounce_ticks;
  logic [TICKS_W-1:0]  repeat_delay_ticks;
  logic [TICKS_W-1:0]  repeat_interval_ticks;
  logic [LEVELS_W-1:0] repeat_mask;

  // Tracking state.
  phase_t              phase, phase_next;
  logic [TICKS_W-1:0]  wait_count, wait_count_next;
  logic [INDEX_W-1:0]  held_index, held_index_next;

  logic                s_xfer;
  logic                m_xfer;
  logic                disable_wr;
  logic [LEVELS_W-1:0] scan;
  logic                any_pressed;
  logic [INDEX_W-1:0]  first_index;
  logic                still_held;
  logic                fire_next;
  logic [INDEX_W-1:0]  index_next;

  // The output register frees up in the same cycle its result is taken.
  assign s_tready   = !m_tvalid || m_tready;
  assign s_xfer     = s_tvalid && s_tready;
  assign m_xfer     = m_tvalid && m_tready;
  assign disable_wr = cfg_we && (cfg_index == REG_ENABLE) && !cfg_wdata[0];

  // Only the buttons that exist take part in the priority scan.
  assign scan        = s_tdata & SCAN_MASK;
  assign any_pressed = |scan;
  assign still_held  = s_tdata[held_index];

  // Priority encoder: bit 0 wins, so scan from the top down.
  always_comb begin
    first_index = '0;
    for (int i = LEVELS_W - 1; i >= 0; i--) begin
      if (scan[i]) begin
        first_index = INDEX_W'(i);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable                <= 1'b0;
      debounce_ticks        <= DEBOUNCE_RESET;
      repeat_delay_ticks    <= DELAY_RESET;
      repeat_interval_ticks <= INTERVAL_RESET;
      repeat_mask           <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:   enable                <= cfg_wdata[0];
        REG_DEBOUNCE: debounce_ticks        <= cfg_wdata;
        REG_DELAY:    repeat_delay_ticks    <= cfg_wdata;
        REG_INTERVAL: repeat_interval_ticks <= cfg_wdata;
        REG_MASK:     repeat_mask           <= cfg_wdata[LEVELS_W-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Next state and result for the tick that is being transferred in.
  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    held_index_next = held_index;
    fire_next       = 1'b0;
    index_next      = '0;

    if (s_xfer) begin
      if (!enable) begin
        phase_next      = PH_IDLE;
        wait_count_next = '0;
      end else begin
        unique case (phase)
          PH_IDLE: begin
            if (any_pressed) begin
              held_index_next = first_index;
              fire_next       = 1'b1;
              index_next      = first_index;
              phase_next      = PH_DEBOUNCE;
              wait_count_next = load_wait(debounce_ticks);
            end
          end
          PH_DEBOUNCE, PH_REPEAT: begin
            if (wait_count > TICKS_W'(1)) begin
              wait_count_next = wait_count - TICKS_W'(1);
            end else if (!still_held) begin
              // Released: idle from the next tick, no new press on this one.
              phase_next      = PH_IDLE;
              wait_count_next = '0;
            end else if (phase == PH_DEBOUNCE) begin
              if (repeat_mask[held_index]) begin
                phase_next      = PH_REPEAT;
                wait_count_next = load_wait(repeat_delay_ticks);
              end else begin
                wait_count_next = load_wait(debounce_ticks);
              end
            end else begin
              fire_next       = 1'b1;
              index_next      = held_index;
              wait_count_next = load_wait(repeat_interval_ticks);
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end
        endcase
      end
    end

    // Clearing enable drops the block to idle right away.
    if (disable_wr) begin
      phase_next      = PH_IDLE;
      wait_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
      held_index <= '0;
    end else begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      held_index <= held_index_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_xfer) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      m_tdata <= {{(OUT_DATA_W - INDEX_W - 1){1'b0}}, index_next, fire_next};
    end
  end

  // A wait is running exactly when the block is not idle.
  `BDA_ASSERT_PROP(a_wait_matches_phase, clk, rst,
    (phase == PH_IDLE) == (wait_count == '0), "wait count disagrees with phase")
  // While disabled the block is always idle.
  `BDA_ASSERT_NEVER(a_idle_when_disabled, clk, rst,
    !enable && (phase != PH_IDLE), "block left idle while disabled")
  // A press seen while enabled and idle is reported on the next result.
  `BDA_ASSERT_PROP(a_press_fires, clk, rst,
    (s_xfer && enable && (phase == PH_IDLE) && any_pressed) |=> (m_tvalid && m_tdata[0]),
    "press taken while idle was not reported")
  // The reported index is zero whenever fire is clear.
  `BDA_ASSERT_PROP(a_quiet_index_zero, clk, rst,
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:1] == '0), "index set without fire")

endmodule
